/* rtl/assert_macros.svh */
// Assertion macros for the top RTL file of the key and button state tracker.
// Needs nothing else; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/kbst_pkg.sv */
// Types and constants of the key and button state tracker.
// Used by kbst_key_bank and key_button_state_tracker; depends on nothing.
package kbst_pkg;

    localparam int NUM_KEYS    = 256;
    localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
    localparam int NUM_BUTTONS = 5;
    localparam int BTN_IDX_W   = 3;
    localparam int MASK_W      = 16;
    localparam int TIME_W      = 32;
    localparam int BUTTON_LSB  = 8;

    localparam logic [KEY_IDX_W-1:0] KEY_LAST = KEY_IDX_W'(NUM_KEYS - 1);

    localparam logic [KEY_IDX_W-1:0] KEY_CONTROL_L = 8'd37;
    localparam logic [KEY_IDX_W-1:0] KEY_CONTROL_R = 8'd105;
    localparam logic [KEY_IDX_W-1:0] KEY_SHIFT_L   = 8'd50;
    localparam logic [KEY_IDX_W-1:0] KEY_SHIFT_R   = 8'd62;
    localparam logic [KEY_IDX_W-1:0] KEY_MOD1_L    = 8'd64;
    localparam logic [KEY_IDX_W-1:0] KEY_MOD1_R    = 8'd108;

    // Positions of the modifier keys in the key bank's shadow register.
    localparam int NUM_TAPS      = 6;
    localparam int TAP_CONTROL_L = 0;
    localparam int TAP_CONTROL_R = 1;
    localparam int TAP_SHIFT_L   = 2;
    localparam int TAP_SHIFT_R   = 3;
    localparam int TAP_MOD1_L    = 4;
    localparam int TAP_MOD1_R    = 5;

    localparam logic [MASK_W-1:0] MASK_SHIFT   = 16'h0001;
    localparam logic [MASK_W-1:0] MASK_CONTROL = 16'h0004;
    localparam logic [MASK_W-1:0] MASK_MOD1    = 16'h0008;

    localparam logic [TIME_W-1:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        KIND_KEY       = 3'd0,
        KIND_BUTTON    = 3'd1,
        KIND_TICK      = 3'd2,
        KIND_MONO_TIME = 3'd3,
        KIND_WRAP_TIME = 3'd4,
        KIND_RESET     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_BUTTON  = 2'd1,
        ST_REPEAT      = 2'd2,
        ST_TIME_REJECT = 2'd3
    } status_t;

    // Update request from the event logic to the key bank.
    typedef struct packed {
        logic                 we;
        logic                 clear;
        logic [KEY_IDX_W-1:0] idx;
        logic                 val;
    } key_req_t;

endpackage

/* rtl/kbst_key_bank.sv */
// Down bit for every keycode in a memory with a registered read port and a clearing pass,
// plus a shadow register of the six modifier keys. Depends on kbst_pkg.
module kbst_key_bank (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [kbst_pkg::KEY_IDX_W-1:0] rd_idx,
    input  kbst_pkg::key_req_t             req,
    output logic                           key_cur,
    output logic [kbst_pkg::MASK_W-1:0]    mod_next,
    output logic                           busy
);
    import kbst_pkg::*;

    logic                 key_mem [NUM_KEYS];
    logic                 key_cur_reg;
    logic                 busy_reg, busy_next;
    logic [KEY_IDX_W-1:0] sweep_reg, sweep_next;
    logic [NUM_TAPS-1:0]  tap_reg, tap_next;
    logic                 wr_en;
    logic [KEY_IDX_W-1:0] wr_idx;
    logic                 wr_val;

    // A clearing pass writes zero to one key per cycle, starting at key zero.
    assign busy_next  = busy_reg ? (sweep_reg != KEY_LAST) : req.clear;
    assign sweep_next = busy_reg ? (sweep_reg + KEY_IDX_W'(1)) : '0;

    assign wr_en  = busy_reg || req.we;
    assign wr_idx = busy_reg ? sweep_reg : req.idx;
    assign wr_val = busy_reg ? 1'b0 : req.val;

    always_comb
    begin
        tap_next = tap_reg;
        if (req.clear)
        begin
            tap_next = '0;
        end
        else if (req.we)
        begin
            case (req.idx)
                KEY_CONTROL_L:
                begin
                    tap_next[TAP_CONTROL_L] = req.val;
                end
                KEY_CONTROL_R:
                begin
                    tap_next[TAP_CONTROL_R] = req.val;
                end
                KEY_SHIFT_L:
                begin
                    tap_next[TAP_SHIFT_L] = req.val;
                end
                KEY_SHIFT_R:
                begin
                    tap_next[TAP_SHIFT_R] = req.val;
                end
                KEY_MOD1_L:
                begin
                    tap_next[TAP_MOD1_L] = req.val;
                end
                KEY_MOD1_R:
                begin
                    tap_next[TAP_MOD1_R] = req.val;
                end
                default:
                begin
                    tap_next = tap_reg;
                end
            endcase
        end
    end

    // The modifiers follow the key bits after this request.
    always_comb
    begin
        mod_next = '0;
        if (tap_next[TAP_CONTROL_L] || tap_next[TAP_CONTROL_R])
        begin
            mod_next = mod_next | MASK_CONTROL;
        end
        if (tap_next[TAP_SHIFT_L] || tap_next[TAP_SHIFT_R])
        begin
            mod_next = mod_next | MASK_SHIFT;
        end
        if (tap_next[TAP_MOD1_L] || tap_next[TAP_MOD1_R])
        begin
            mod_next = mod_next | MASK_MOD1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            sweep_reg <= sweep_next;
            tap_reg   <= tap_next;
        end
    end

    // The key of a new request is read as it is accepted; a write to the same key in that
    // cycle is passed straight through.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_idx] <= wr_val;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_idx == rd_idx))
            begin
                key_cur_reg <= wr_val;
            end
            else
            begin
                key_cur_reg <= key_mem[rd_idx];
            end
        end
    end

    assign key_cur = key_cur_reg;
    assign busy    = busy_reg;

endmodule

/* rtl/key_button_state_tracker.sv */
// Key and pointer-button state tracker: input register, event logic, result register.
// A request accepted into the input register goes into the result register once that is free.
// One request per cycle; the input stalls when both registers are full and held, or in a key
// clearing pass. A reset event blocks input while it waits and during its key clearing pass.
// Reset clears buttons, modifiers, time and both valid flags, then runs the same pass.
// Depends on kbst_pkg, kbst_key_bank and assert_macros.svh.
`include "assert_macros.svh"
module key_button_state_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // code[7:0], pressed[8], time_stamp[40:9], zero pad
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // mask_bits[15:0], buttons_held[20:16],
                                        // any_button[21], current_time[53:22], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import kbst_pkg::*;

    // Input register.
    logic                   in_valid_reg, in_valid_next;
    kind_t                  kind_reg;
    logic [KEY_IDX_W-1:0]   code_reg;
    logic                   pressed_reg;
    logic [TIME_W-1:0]      ts_reg;

    // State.
    logic [NUM_BUTTONS-1:0] btn_reg, btn_next;
    logic [TIME_W-1:0]      time_reg, time_next;

    // Result register.
    logic                   out_valid_reg, out_valid_next;
    status_t                status_reg, status_next;
    logic [MASK_W-1:0]      mask_reg, mask_next;
    logic [NUM_BUTTONS-1:0] held_reg;
    logic                   any_reg;
    logic [TIME_W-1:0]      cur_time_reg;

    logic                   in_take;
    logic                   load_out;
    logic                   reset_held;
    key_req_t               key_req;
    logic                   key_cur;
    logic                   key_busy;
    logic [MASK_W-1:0]      mod_next;
    logic                   btn_valid;
    logic [BTN_IDX_W-1:0]   btn_idx;
    logic [NUM_BUTTONS-1:0] btn_bit;
    logic                   btn_cur;
    logic                   load_not_wrap;
    logic                   load_reject;
    logic                   load_reset;

    // Nothing follows a reset event into the block until the key clearing pass is over.
    assign reset_held    = in_valid_reg && (kind_reg == KIND_RESET);
    assign load_out      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !key_busy && !reset_held && (!in_valid_reg || load_out);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_take ? 1'b1 : (load_out ? 1'b0 : in_valid_reg);
    assign out_valid_next = load_out ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    assign btn_valid = (code_reg != '0) && (code_reg <= KEY_IDX_W'(NUM_BUTTONS));
    assign btn_idx   = BTN_IDX_W'(code_reg - KEY_IDX_W'(1));
    assign btn_bit   = btn_valid ? (NUM_BUTTONS'(1) << btn_idx) : '0;
    assign btn_cur   = |(btn_reg & btn_bit);

    kbst_key_bank u_key_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_take),
        .rd_idx   (s_axis_tdata[7:0]),
        .req      (key_req),
        .key_cur  (key_cur),
        .mod_next (mod_next),
        .busy     (key_busy)
    );

    always_comb
    begin
        key_req.we    = 1'b0;
        key_req.clear = 1'b0;
        key_req.idx   = code_reg;
        key_req.val   = pressed_reg;
        btn_next      = btn_reg;
        time_next     = time_reg;
        status_next   = ST_OK;
        case (kind_reg)
            KIND_KEY:
            begin
                if (key_cur == pressed_reg)
                begin
                    status_next = ST_REPEAT;
                end
                else
                begin
                    key_req.we = load_out;
                end
            end
            KIND_BUTTON:
            begin
                if (!btn_valid)
                begin
                    status_next = ST_BAD_BUTTON;
                end
                else if (btn_cur == pressed_reg)
                begin
                    status_next = ST_REPEAT;
                end
                else if (pressed_reg)
                begin
                    btn_next = btn_reg | btn_bit;
                end
                else
                begin
                    btn_next = btn_reg & ~btn_bit;
                end
            end
            KIND_TICK:
            begin
                if (time_reg != TIME_MAX)
                begin
                    time_next = time_reg + TIME_W'(1);
                end
            end
            KIND_MONO_TIME:
            begin
                if ((ts_reg == '0) || (ts_reg < time_reg))
                begin
                    status_next = ST_TIME_REJECT;
                end
                else
                begin
                    time_next = ts_reg;
                end
            end
            KIND_WRAP_TIME:
            begin
                if (ts_reg == '0)
                begin
                    status_next = ST_TIME_REJECT;
                end
                else
                begin
                    time_next = ts_reg;
                end
            end
            KIND_RESET:
            begin
                key_req.clear = load_out;
                btn_next      = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign mask_next = mod_next | (MASK_W'(btn_next) << BUTTON_LSB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            btn_reg       <= '0;
            time_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                btn_reg  <= btn_next;
                time_reg <= time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg    <= kind_t'(s_axis_tuser);
            code_reg    <= s_axis_tdata[7:0];
            pressed_reg <= s_axis_tdata[8];
            ts_reg      <= s_axis_tdata[40:9];
        end
        if (load_out)
        begin
            status_reg   <= status_next;
            mask_reg     <= mask_next;
            held_reg     <= btn_next;
            any_reg      <= |btn_next;
            cur_time_reg <= time_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {2'b00, cur_time_reg, any_reg, held_reg, mask_reg};

    assign load_not_wrap = load_out && (kind_reg != KIND_WRAP_TIME);
    assign load_reject   = load_out && (status_next == ST_TIME_REJECT);
    assign load_reset    = load_out && (kind_reg == KIND_RESET);

    // Only a wrapping timestamp may move the stored time backwards.
    `ASSERT_SAME(a_time_monotonic, clk, rst_n, load_not_wrap, time_next >= time_reg)
    // A rejected timestamp leaves the stored time alone.
    `ASSERT_SAME(a_reject_keeps_time, clk, rst_n, load_reject, time_next == time_reg)
    // A reset event leaves no button and no modifier set in its result.
    `ASSERT_NEXT(a_reset_clears, clk, rst_n, load_reset, (btn_reg == '0) && (mask_reg == '0))

endmodule
